>>> rtl/core/message_ring_deque_core_defines.svh
// Assertion macros for the message ring deque core.
`ifndef MESSAGE_RING_DEQUE_CORE_DEFINES_SVH
`define MESSAGE_RING_DEQUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MRD_ASSERT(lbl, prop, txt) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(txt);
`define MRD_ASSERT_ALWAYS(lbl, prop, txt) \
    lbl: assert property (@(posedge i_clk) prop) else $error(txt);
`else
`define MRD_ASSERT(lbl, prop, txt)
`define MRD_ASSERT_ALWAYS(lbl, prop, txt)
`endif

`endif

>>> rtl/core/mrd_pkg.sv
package mrd_pkg;

    localparam int FUNC_W     = 2;
    localparam int ST_W       = 2;
    localparam int PORT_MSG_W = 32;
    localparam int CNT_W      = 5;

    localparam int DEPTH_DEF     = 16;
    localparam int MSG_WIDTH_DEF = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    localparam logic [FUNC_W-1:0] FUNC_SEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_JAM  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RECV = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic take;
        logic load_rd;
    } t_cmd;

    typedef struct packed {
        logic rd_pend;
    } t_sts;

endpackage

>>> rtl/core/mrd_req_if.sv
interface mrd_req_if;
    import mrd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FUNC_W-1:0]     func;
    logic [PORT_MSG_W-1:0] msg_in;

    modport source (output valid, output func, output msg_in, input ready);
    modport sink   (input valid, input func, input msg_in, output ready);
endinterface

>>> rtl/core/mrd_rsp_if.sv
interface mrd_rsp_if;
    import mrd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ST_W-1:0]       status;
    logic [PORT_MSG_W-1:0] msg_out;
    logic [CNT_W-1:0]      fill_count;

    modport source (output valid, output status, output msg_out, output fill_count,
                    input ready);
    modport sink   (input valid, input status, input msg_out, input fill_count,
                    output ready);
endinterface

>>> rtl/core/mrd_ram.sv
module mrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/mrd_ctrl.sv
module mrd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    input  mrd_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output mrd_pkg::t_cmd o_cmd
);
    import mrd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       in_ready;
    logic       take;

    assign in_ready = (r_state == S_IDLE) || ((r_state == S_OUT) && i_out_ready);
    assign take     = i_in_valid && in_ready;

    always_comb begin
        n_state = r_state;
        priority if (take) begin
            n_state = i_sts.rd_pend ? S_RD : S_OUT;
        end else if (r_state == S_RD) begin
            n_state = S_OUT;
        end else if ((r_state == S_OUT) && i_out_ready) begin
            n_state = S_IDLE;
        end else if (r_state != S_OUT) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready    = in_ready;
    assign o_out_valid   = (r_state == S_OUT);
    assign o_cmd.take    = take;
    assign o_cmd.load_rd = (r_state == S_RD);
endmodule

>>> rtl/core/mrd_dp.sv
module mrd_dp #(
    parameter int DEPTH     = mrd_pkg::DEPTH_DEF,
    parameter int MSG_WIDTH = mrd_pkg::MSG_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mrd_pkg::t_cmd                  i_cmd,
    input  logic [mrd_pkg::FUNC_W-1:0]     i_func,
    input  logic [mrd_pkg::PORT_MSG_W-1:0] i_msg_in,
    input  logic                           i_cfg_we,
    input  logic [mrd_pkg::CNT_W-1:0]      i_cfg_wdata,
    output mrd_pkg::t_sts                  o_sts,
    output logic [mrd_pkg::ST_W-1:0]       o_status,
    output logic [mrd_pkg::PORT_MSG_W-1:0] o_msg_out,
    output logic [mrd_pkg::CNT_W-1:0]      o_fill_count
);
    import mrd_pkg::*;

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W   = CNT_W + 1;
    localparam int CAP_MAX = (DEPTH < (2 ** CNT_W - 1)) ? DEPTH : (2 ** CNT_W - 1);
    localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CAP_MAX);

    logic [CNT_W-1:0]      r_cap;
    logic [IDX_W-1:0]      r_head;
    logic [CNT_W-1:0]      r_count;
    logic [ST_W-1:0]       r_status;
    logic [PORT_MSG_W-1:0] r_msg;
    logic [CNT_W-1:0]      r_fill;

    logic [IDX_W-1:0]      n_head;
    logic [CNT_W-1:0]      n_count;
    logic [ST_W-1:0]       n_status;

    logic [CNT_W-1:0]      cap_eff;
    logic [SUM_W-1:0]      cap_x;
    logic [SUM_W-1:0]      head_x;
    logic [SUM_W-1:0]      tail_sum;
    logic [SUM_W-1:0]      jam_sum;
    logic [SUM_W-1:0]      adv_sum;
    logic [SUM_W-1:0]      tail_pos;
    logic [SUM_W-1:0]      jam_pos;
    logic [SUM_W-1:0]      adv_pos;
    logic                  full;
    logic                  empty;
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [MSG_WIDTH-1:0]  wdata;
    logic [MSG_WIDTH-1:0]  rdata;

    always_comb begin
        priority if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (r_cap > CAP_LIM) begin
            cap_eff = CAP_LIM;
        end else begin
            cap_eff = r_cap;
        end
    end

    assign cap_x    = SUM_W'(cap_eff);
    assign head_x   = SUM_W'(r_head);
    assign full     = (r_count >= cap_eff);
    assign empty    = (r_count == '0);

    // every sum stays below twice the capacity: one subtract wraps it
    assign tail_sum = head_x + SUM_W'(r_count);
    assign jam_sum  = head_x + cap_x - SUM_W'(1);
    assign adv_sum  = head_x + SUM_W'(1);
    assign tail_pos = (tail_sum >= cap_x) ? tail_sum - cap_x : tail_sum;
    assign jam_pos  = (jam_sum >= cap_x) ? jam_sum - cap_x : jam_sum;
    assign adv_pos  = (adv_sum >= cap_x) ? adv_sum - cap_x : adv_sum;

    assign wdata = MSG_WIDTH'(i_msg_in);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_DONE;
        we       = 1'b0;
        waddr    = IDX_W'(tail_pos);
        unique case (i_func)
            FUNC_SEND: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            FUNC_JAM: begin
                waddr = IDX_W'(jam_pos);
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_head  = IDX_W'(jam_pos);
                    n_count = r_count + CNT_W'(1);
                end
            end
            FUNC_RECV: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head  = IDX_W'(adv_pos);
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.rd_pend = (i_func == FUNC_RECV) && !empty;

    mrd_ram #(
        .WIDTH (MSG_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we && i_cmd.take),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_cap   <= i_cfg_wdata;
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.take) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_status <= n_status;
            r_msg    <= '0;
            r_fill   <= n_count;
        end else if (i_cmd.load_rd) begin
            r_msg    <= PORT_MSG_W'(rdata);
        end
    end

    assign o_status     = r_status;
    assign o_msg_out    = r_msg;
    assign o_fill_count = r_fill;
endmodule

>>> rtl/core/message_ring_deque_core.sv
// Message ring deque: a queue of message words in a ring of DEPTH slots, of which the
// capacity register selects how many are used (0 acts as 1, above DEPTH acts as DEPTH).
// Each request sends at the tail, jams ahead of the head or receives from the head, and
// gives one response with status (done, full or empty), the received word (zero unless a
// receive succeeded) and the fill count after the request. Writing capacity empties the
// queue. A taken request's response is registered the next cycle; a successful receive
// adds a slot read state (registered read port), in which no request is taken. A new
// request is taken in the cycle its predecessor's response is taken, so sends, jams and
// failed requests sustain one per cycle while each response is taken at once.
`include "message_ring_deque_core_defines.svh"

module message_ring_deque_core #(
    parameter int DEPTH     = mrd_pkg::DEPTH_DEF,
    parameter int MSG_WIDTH = mrd_pkg::MSG_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    mrd_req_if.sink                   i_req,
    mrd_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_we,
    input  logic [mrd_pkg::CNT_W-1:0] i_cfg_wdata
);
    import mrd_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_out_valid;

    mrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    mrd_dp #(
        .DEPTH     (DEPTH),
        .MSG_WIDTH (MSG_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_func       (i_req.func),
        .i_msg_in     (i_req.msg_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_sts        (w_sts),
        .o_status     (o_rsp.status),
        .o_msg_out    (o_rsp.msg_out),
        .o_fill_count (o_rsp.fill_count)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

    `MRD_ASSERT(a_fail_no_msg, (o_rsp.valid && (o_rsp.status != ST_DONE)) |-> (o_rsp.msg_out == '0), "failed request returned a message")
    `MRD_ASSERT(a_empty_count, (o_rsp.valid && (o_rsp.status == ST_EMPTY)) |-> (o_rsp.fill_count == '0), "empty status with nonzero fill count")
    `MRD_ASSERT(a_full_count, (o_rsp.valid && (o_rsp.status == ST_FULL)) |-> (o_rsp.fill_count != '0), "full status with zero fill count")
    `MRD_ASSERT(a_rd_then_out, w_cmd.load_rd |=> (o_rsp.valid && !w_cmd.load_rd), "read data not presented after slot read")
    `MRD_ASSERT_ALWAYS(a_no_take_in_rd, !i_rst_n || !(w_cmd.load_rd && w_in_ready), "take in read")
endmodule
